// ----- rtl/core/rth_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rth_pkg;

	// Which channel is largest, ties resolved red, then green, then blue.
	typedef enum logic [1:0] {
		SEC_RED = 2'd0,
		SEC_GRN = 2'd1,
		SEC_BLU = 2'd2
	} sec_t;

	// Hue sector geometry in whole degrees.
	localparam int DEG_SECTOR = 60;
	localparam int DEG_GRN    = 120;
	localparam int DEG_BLU    = 240;
	localparam int DEG_FULL   = 360;

	// Channel and result field widths.
	localparam int CH_W  = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 13;

	// Sideband that travels with the hue quotient.
	typedef struct packed {
		sec_t sector;
		logic neg;
		logic grey;
	} hue_side_t;

endpackage

// ----- rtl/core/rth_prep.sv -----
// Front end of the converter: max/min, chroma, sector and the two dividends.
// Two register stages. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_prep import rth_pkg::*; #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12,
	parameter int QW            = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  logic [CH_W-1:0]     red,
	input  logic [CH_W-1:0]     green,
	input  logic [CH_W-1:0]     blue,
	output logic                res_vld,
	output logic [QW+CH_W-1:0]  hue_num,
	output logic [CH_W-1:0]     hue_den,
	output logic [QW+CH_W-1:0]  sat_num,
	output logic [CH_W-1:0]     sat_den,
	output hue_side_t           side
);

	localparam int NW = QW + CH_W;
	localparam int PW = CH_W + 6;

	logic [CH_W-1:0] mx, mn;
	sec_t            sector;
	logic [CH_W:0]   diff;
	logic [CH_W:0]   diff_neg;

	logic            vld_s1;
	logic [CH_W-1:0] abs_s1;
	logic            neg_s1;
	sec_t            sector_s1;
	logic [CH_W-1:0] chroma_s1;
	logic [CH_W-1:0] mx_s1;

	logic            vld_s2;
	logic [NW-1:0]   hue_num_s2;
	logic [NW-1:0]   sat_num_s2;
	logic [CH_W-1:0] chroma_s2;
	logic [CH_W-1:0] mx_s2;
	hue_side_t       side_s2;

	logic [PW-1:0]   prod;
	logic [NW-1:0]   hue_base;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;

		if (mx == red) begin
			sector = SEC_RED;
			diff   = {1'b0, green} - {1'b0, blue};
		end else if (mx == green) begin
			sector = SEC_GRN;
			diff   = {1'b0, blue} - {1'b0, red};
		end else begin
			sector = SEC_BLU;
			diff   = {1'b0, red} - {1'b0, green};
		end
		diff_neg = '0 - diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		abs_s1    <= diff[CH_W] ? diff_neg[CH_W-1:0] : diff[CH_W-1:0];
		neg_s1    <= diff[CH_W];
		sector_s1 <= sector;
		chroma_s1 <= mx - mn;
		mx_s1     <= mx;
	end

	// A negative offset needs the ceiling of its magnitude over chroma, so
	// chroma minus one is added to the dividend before the floor division.
	assign prod     = PW'(abs_s1) * PW'(DEG_SECTOR);
	assign hue_base = NW'(prod) << HUE_FRAC_BITS;

	always_ff @(posedge clk) begin
		hue_num_s2     <= neg_s1 ? hue_base + NW'(chroma_s1) - NW'(1) : hue_base;
		sat_num_s2     <= NW'(chroma_s1) << SAT_FRAC_BITS;
		chroma_s2      <= chroma_s1;
		mx_s2          <= mx_s1;
		side_s2.sector <= sector_s1;
		side_s2.neg    <= neg_s1;
		side_s2.grey   <= (chroma_s1 == '0);
	end

	assign res_vld = vld_s2;
	assign hue_num = hue_num_s2;
	assign hue_den = chroma_s2;
	assign sat_num = sat_num_s2;
	assign sat_den = mx_s2;
	assign side    = side_s2;

endmodule

// ----- rtl/core/rth_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// The dividend must be below den * 2^QW. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_div import rth_pkg::*; #(
	parameter int QW = 13,
	parameter int TW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  logic [QW+CH_W-1:0] num,
	input  logic [CH_W-1:0]    den,
	input  logic [TW-1:0]      tag,
	output logic               res_vld,
	output logic [QW-1:0]      quo,
	output logic [TW-1:0]      res_tag
);

	localparam int NW = QW + CH_W;

	logic [NW-1:0]   rem_in [QW];
	logic [QW-1:0]   quo_in [QW];
	logic [CH_W-1:0] den_in [QW];
	logic [TW-1:0]   tag_in [QW];
	logic [NW:0]     trial  [QW];

	logic [NW-1:0]   rem_s [1:QW-1];
	logic [QW-1:0]   quo_s [1:QW];
	logic [CH_W-1:0] den_s [1:QW-1];
	logic [TW-1:0]   tag_s [1:QW];
	logic            vld_s [1:QW];

	always_comb begin
		rem_in[0] = num;
		quo_in[0] = '0;
		den_in[0] = den;
		tag_in[0] = tag;
		for (int i = 1; i < QW; i++) begin
			rem_in[i] = rem_s[i];
			quo_in[i] = quo_s[i];
			den_in[i] = den_s[i];
			tag_in[i] = tag_s[i];
		end
		// Stage i decides quotient bit QW-1-i.
		for (int i = 0; i < QW; i++) begin
			trial[i] = {1'b0, rem_in[i]} - ((NW+1)'(den_in[i]) << (QW - 1 - i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= QW; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= vld;
			for (int i = 2; i <= QW; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QW; i++) begin
			if (i < QW - 1) begin
				rem_s[i+1] <= trial[i][NW] ? rem_in[i] : trial[i][NW-1:0];
				den_s[i+1] <= den_in[i];
			end
			quo_s[i+1] <= quo_in[i] | (trial[i][NW] ? '0 : (QW'(1) << (QW - 1 - i)));
			tag_s[i+1] <= tag_in[i];
		end
	end

	assign res_vld = vld_s[QW];
	assign quo     = quo_s[QW];
	assign res_tag = tag_s[QW];

endmodule

// ----- rtl/core/rth_post.sv -----
// Back end of the converter: places the hue offset in its sector, wraps
// negative hue, forces the grey and black cases. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_post import rth_pkg::*; #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12,
	parameter int QW            = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hue_vld,
	input  logic             sat_vld,
	input  logic [QW-1:0]    hue_quo,
	input  logic [QW-1:0]    sat_quo,
	input  hue_side_t        side,
	input  logic [CH_W-1:0]  val,
	output logic             done,
	output logic [HUE_W-1:0] hue,
	output logic [SAT_W-1:0] sat,
	output logic [CH_W-1:0]  value
);

	localparam int HQB = 6 + HUE_FRAC_BITS;
	localparam int HWW = 9 + HUE_FRAC_BITS;
	localparam int HXW = (HWW > HUE_W) ? HWW : HUE_W;
	localparam int SQB = SAT_FRAC_BITS + 1;
	localparam int SXW = (SQB > SAT_W) ? SQB : SAT_W;

	logic [HWW-1:0] hq;
	logic [HWW-1:0] base;
	logic [HWW-1:0] hue_w;
	logic [HXW-1:0] hue_x;
	logic [SXW-1:0] sat_x;

	logic             done_q;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [CH_W-1:0]  val_q;

	assign hq = HWW'(hue_quo[HQB-1:0]);

	always_comb begin
		case (side.sector)
			SEC_RED: base = side.neg ? (HWW'(DEG_FULL) << HUE_FRAC_BITS) : '0;
			SEC_GRN: base = HWW'(DEG_GRN) << HUE_FRAC_BITS;
			SEC_BLU: base = HWW'(DEG_BLU) << HUE_FRAC_BITS;
			default: base = '0;
		endcase
		if (side.grey) begin
			hue_w = '0;
		end else if (side.neg) begin
			hue_w = base - hq;
		end else begin
			hue_w = base + hq;
		end
		hue_x = HXW'(hue_w);
		sat_x = (val == '0) ? '0 : SXW'(sat_quo[SQB-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hue_vld & sat_vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_q <= hue_x[HUE_W-1:0];
		sat_q <= sat_x[SAT_W-1:0];
		val_q <= val;
	end

	assign done  = done_q;
	assign hue   = hue_q;
	assign sat   = sat_q;
	assign value = val_q;

endmodule

// ----- rtl/core/rgb_to_hsv_convert.sv -----
// Top level of the RGB to HSV converter: front end, two pipelined dividers
// and back end. Depends on rth_pkg, rth_prep, rth_div and rth_post.
//
// Usage: drive red_in, green_in and blue_in and raise start for one cycle per
// pixel; a beat is taken at every rising edge with start high. busy is always
// low, so a new pixel may be presented in every cycle.
// Each result beat appears on hue_out, sat_out and val_out for exactly one
// cycle with done high, in the order the pixels went in.
// The path runs through two front-end stages, QW stages of the hue and
// saturation dividers side by side (one quotient bit each), and one output
// stage, where QW = max(HUE_FRAC_BITS + 6, SAT_FRAC_BITS + 1) is the
// number of divider stages.
// Throughput is one pixel per cycle, set by the fully pipelined dividers.
// Reset clears every valid bit at once; no beat comes out until a pixel has
// gone in after reset. There is no back pressure from the receiver, so no
// beat is ever held or dropped inside the block.
`timescale 1ns / 1ps

module rgb_to_hsv_convert import rth_pkg::*; #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CH_W-1:0]  red_in,
	input  logic [CH_W-1:0]  green_in,
	input  logic [CH_W-1:0]  blue_in,
	output logic             done,
	output logic [HUE_W-1:0] hue_out,
	output logic [SAT_W-1:0] sat_out,
	output logic [CH_W-1:0]  val_out
);

	localparam int HQ  = HUE_FRAC_BITS + 6;
	localparam int SQ  = SAT_FRAC_BITS + 1;
	localparam int QW  = (HQ > SQ) ? HQ : SQ;
	localparam int NW  = QW + CH_W;
	localparam int LAT = QW + 3;
	localparam int SDW = $bits(hue_side_t);

	logic            pre_vld;
	logic [NW-1:0]   hue_num, sat_num;
	logic [CH_W-1:0] hue_den, sat_den;
	hue_side_t       pre_side;

	logic            hue_vld, sat_vld;
	logic [QW-1:0]   hue_quo, sat_quo;
	logic [SDW-1:0]  hue_tag;
	logic [CH_W-1:0] val_tag;

	assign busy = 1'b0;

	rth_prep #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS),
		.QW(QW)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.vld(start & ~busy),
		.red(red_in),
		.green(green_in),
		.blue(blue_in),
		.res_vld(pre_vld),
		.hue_num(hue_num),
		.hue_den(hue_den),
		.sat_num(sat_num),
		.sat_den(sat_den),
		.side(pre_side)
	);

	rth_div #(.QW(QW), .TW(SDW)) u_hue_div (
		.clk(clk),
		.arst_n(arst_n),
		.vld(pre_vld),
		.num(hue_num),
		.den(hue_den),
		.tag(pre_side),
		.res_vld(hue_vld),
		.quo(hue_quo),
		.res_tag(hue_tag)
	);

	// The saturation divider carries the value channel as its sideband.
	rth_div #(.QW(QW), .TW(CH_W)) u_sat_div (
		.clk(clk),
		.arst_n(arst_n),
		.vld(pre_vld),
		.num(sat_num),
		.den(sat_den),
		.tag(sat_den),
		.res_vld(sat_vld),
		.quo(sat_quo),
		.res_tag(val_tag)
	);

	rth_post #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS),
		.QW(QW)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.hue_vld(hue_vld),
		.sat_vld(sat_vld),
		.hue_quo(hue_quo),
		.sat_quo(sat_quo),
		.side(hue_side_t'(hue_tag)),
		.val(val_tag),
		.done(done),
		.hue(hue_out),
		.sat(sat_out),
		.value(val_out)
	);

`ifndef ASSERT_OFF
	// Both divider lanes must stay in lockstep.
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		hue_vld == sat_vld)
		else $error("hue and saturation dividers out of step");

	// Every accepted pixel produces its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing at expected latency");

	// A result beat always traces back to an accepted pixel.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without an accepted pixel");

	// A black pixel has zero saturation and zero hue.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && val_out == '0) |-> (sat_out == '0 && hue_out == '0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
